// ===== rtl/dtw_pkg.sv =====
// Shared types, calendar tables and the mod-7 reduction for date_to_weekday.
// No dependencies.
package dtw_pkg;

   localparam int unsigned DayWidth   = 6;
   localparam int unsigned MonthWidth = 4;
   localparam int unsigned YearWidth  = 12;
   localparam int unsigned WdayWidth  = 3;
   localparam int unsigned ReqWidth   = 24;
   localparam int unsigned RspWidth   = 8;
   localparam int unsigned SumWidth   = 13;

   localparam logic [YearWidth-1:0]  FirstYear = 12'd2001;
   localparam logic [MonthWidth-1:0] MonthJan  = 4'd1;
   localparam logic [MonthWidth-1:0] MonthFeb  = 4'd2;
   localparam logic [MonthWidth-1:0] MonthDec  = 4'd12;

   // cancels the leap-day count (FirstYear-1)/4 = 500 at 2001: -500 taken mod 7
   localparam logic [2:0] BaseOffset = 3'd4;

   typedef struct packed {
      logic date_ok;
      logic leap;
   } date_chk_type;

   function automatic logic [DayWidth-1:0] month_len(input logic [MonthWidth-1:0] month,
                                                     input logic leap);
      logic [DayWidth-1:0] len;
      begin
         case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 6'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   len = 6'd30;
            4'd2:                                       len = leap ? 6'd29 : 6'd28;
            default:                                    len = 6'd0;
         endcase
         return len;
      end
   endfunction

   // cumulative month offset mod 7
   function automatic logic [2:0] month_start_mod7(input logic [MonthWidth-1:0] month);
      logic [2:0] ofs;
      begin
         case (month)
            4'd1:    ofs = 3'd0;
            4'd2:    ofs = 3'd3;
            4'd3:    ofs = 3'd3;
            4'd4:    ofs = 3'd6;
            4'd5:    ofs = 3'd1;
            4'd6:    ofs = 3'd4;
            4'd7:    ofs = 3'd6;
            4'd8:    ofs = 3'd2;
            4'd9:    ofs = 3'd5;
            4'd10:   ofs = 3'd0;
            4'd11:   ofs = 3'd3;
            4'd12:   ofs = 3'd5;
            default: ofs = 3'd0;
         endcase
         return ofs;
      end
   endfunction

   // fold octal digits, since 8 is 1 mod 7
   function automatic logic [WdayWidth-1:0] mod7(input logic [SumWidth-1:0] val);
      logic [4:0] fold1;
      logic [3:0] fold2;
      logic [3:0] rem;
      begin
         fold1 = 5'(val[2:0]) + 5'(val[5:3]) + 5'(val[8:6]) + 5'(val[11:9])
               + 5'(val[12]);
         fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
         rem   = (fold2 >= 4'd7) ? fold2 - 4'd7 : fold2;
         return rem[WdayWidth-1:0];
      end
   endfunction

endpackage

// ===== rtl/dtw_check.sv =====
// Date validity check and leap-year flag for date_to_weekday.
// Depends on dtw_pkg.
module dtw_check
   import dtw_pkg::*;
(
   input  logic [DayWidth-1:0]   day_of_month,
   input  logic [MonthWidth-1:0] month_number,
   input  logic [YearWidth-1:0]  year_number,
   output date_chk_type          chk
);

   logic                month_ok;
   logic [DayWidth-1:0] len;

   always_comb begin
      chk.leap    = (year_number[1:0] == 2'b00);
      month_ok    = (month_number >= MonthJan) && (month_number <= MonthDec);
      len         = month_len(month_number, chk.leap);
      chk.date_ok = (year_number >= FirstYear) && month_ok
                  && (day_of_month != '0) && (day_of_month <= len);
   end

endmodule

// ===== rtl/dtw_weekday.sv =====
// Day count mod 7 from 1 January 2001 for date_to_weekday.
// Depends on dtw_pkg.
module dtw_weekday
   import dtw_pkg::*;
(
   input  logic [DayWidth-1:0]   day_of_month,
   input  logic [MonthWidth-1:0] month_number,
   input  logic [YearWidth-1:0]  year_number,
   input  logic                  leap,
   output logic [WdayWidth-1:0]  weekday
);

   logic [YearWidth-1:0] years;
   logic [YearWidth-1:0] year_m1;
   logic                 adj;
   logic [SumWidth-1:0]  total;

   always_comb begin
      years   = year_number - FirstYear;
      year_m1 = year_number - 12'd1;
      adj     = leap && (month_number > MonthFeb);
      total   = SumWidth'(years) + SumWidth'(year_m1[YearWidth-1:2])
              + SumWidth'(month_start_mod7(month_number)) + SumWidth'(adj)
              + SumWidth'(day_of_month) + SumWidth'(BaseOffset);
      weekday = mod7(total);
   end

endmodule

// ===== rtl/date_to_weekday.sv =====
// Top level of date_to_weekday: input register, check and weekday logic, result register.
// Depends on dtw_pkg, dtw_check and dtw_weekday.
// A request lands in the input register when accepted; its response is registered into the
// result register once that register is empty or drained. Throughput: one transaction per
// cycle while rsp_tready is high; while a response waits, a new request is still taken if the
// input register is free. Reset: synchronous, active high; clears both valid flags.
module date_to_weekday
   import dtw_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqWidth-1:0] req_tdata,  // day_of_month[5:0], month_number[9:6], year_number[21:10]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspWidth-1:0] rsp_tdata,  // weekday[2:0]
   output logic                rsp_tuser   // date_valid[0]
);

   logic                  in_valid_ff, in_valid_in;
   logic [ReqWidth-1:0]   in_data_ff,  in_data_in;
   logic                  out_valid_ff, out_valid_in;
   logic [WdayWidth-1:0]  wday_ff,  wday_in;
   logic                  ok_ff,    ok_in;
   logic                  adv_out;
   logic                  adv_in;
   date_chk_type          chk;
   logic [WdayWidth-1:0]  wday_raw;

   dtw_check u_check (
      .day_of_month (in_data_ff[5:0]),
      .month_number (in_data_ff[9:6]),
      .year_number  (in_data_ff[21:10]),
      .chk          (chk)
   );

   dtw_weekday u_weekday (
      .day_of_month (in_data_ff[5:0]),
      .month_number (in_data_ff[9:6]),
      .year_number  (in_data_ff[21:10]),
      .leap         (chk.leap),
      .weekday      (wday_raw)
   );

   always_comb begin
      adv_out      = !out_valid_ff || rsp_tready;
      adv_in       = !in_valid_ff || adv_out;
      req_tready   = adv_in;
      in_valid_in  = adv_in ? req_tvalid : in_valid_ff;
      in_data_in   = (adv_in && req_tvalid) ? req_tdata : in_data_ff;
      out_valid_in = adv_out ? in_valid_ff : out_valid_ff;
      ok_in        = (adv_out && in_valid_ff) ? chk.date_ok : ok_ff;
      wday_in      = (adv_out && in_valid_ff) ? (chk.date_ok ? wday_raw : '0) : wday_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff <= in_data_in;
      ok_ff      <= ok_in;
      wday_ff    <= wday_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RspWidth'(wday_ff);
   assign rsp_tuser  = ok_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("invalid date with non-zero weekday");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[2:0] != 3'd7))
      else $error("weekday out of range");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("input register lost a transaction under stall");

endmodule

// ===== tb/sv/date_to_weekday_tb.sv =====
// Self-checking testbench for date_to_weekday: streams dates in, predicts each weekday
// and validity flag, and compares every response in order under varied handshake timing.
// Depends on dtw_pkg and the date_to_weekday RTL.
module date_to_weekday_tb
   import dtw_pkg::*;
();

   localparam int unsigned CycleLimit = 200000;

   typedef struct {
      logic [DayWidth-1:0]   day;
      logic [MonthWidth-1:0] month;
      logic [YearWidth-1:0]  year;
      logic [WdayWidth-1:0]  weekday;
      logic                  date_ok;
   } weekday_expect_type;

   int unsigned days_before_month [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                           304, 334};
   int unsigned days_in_month [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqWidth-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspWidth-1:0] rsp_tdata;
   logic                rsp_tuser;

   weekday_expect_type pending_weekdays [$];
   int unsigned     error_count = 0;
   int unsigned     cycle_count = 0;
   int unsigned     send_idle_pct = 0;
   int unsigned     recv_stall_pct = 0;
   int unsigned     hold_request = 0;
   int unsigned     hold_left = 0;

   date_to_weekday u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned month_length(input logic [MonthWidth-1:0] month,
                                                input logic [YearWidth-1:0] year);
      int unsigned len;
      begin
         if (month < 1 || month > 12) begin
            len = 0;
         end else begin
            len = days_in_month[month - 1];
            if (month == 2 && year[1:0] == 2'b00) begin
               len = 29;
            end
         end
         return len;
      end
   endfunction

   function automatic weekday_expect_type predict_weekday(input logic [DayWidth-1:0] day,
                                                          input logic [MonthWidth-1:0] month,
                                                          input logic [YearWidth-1:0] year);
      weekday_expect_type res;
      int unsigned     span;
      int unsigned     yr;
      begin
         res.day     = day;
         res.month   = month;
         res.year    = year;
         res.weekday = '0;
         res.date_ok = 1'b0;
         yr          = 32'(year);
         if (yr >= 2001 && day >= 1 && day <= month_length(month, year)) begin
            span = 365 * (yr - 2001) + ((yr - 1) / 4 - 500) + days_before_month[month - 1];
            if (year[1:0] == 2'b00 && month > 2) begin
               span = span + 1;
            end
            span        = span + 32'(day);
            res.weekday = WdayWidth'(span % 7);
            res.date_ok = 1'b1;
         end
         return res;
      end
   endfunction

   // entered and left at a falling edge
   task automatic send_date(input logic [DayWidth-1:0] day, input logic [MonthWidth-1:0] month,
                            input logic [YearWidth-1:0] year);
      begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= ReqWidth'({year, month, day});
         @(posedge clock);
         while (!req_tready) begin
            @(posedge clock);
         end
         pending_weekdays.push_back(predict_weekday(day, month, year));
         @(negedge clock);
      end
   endtask

   task automatic pick_date(output logic [DayWidth-1:0] day, output logic [MonthWidth-1:0] month,
                            output logic [YearWidth-1:0] year);
      int unsigned len;
      int unsigned kind;
      begin
         if ($urandom_range(99) < 60) begin
            year = YearWidth'($urandom_range(2001, 2100));
         end else begin
            year = YearWidth'($urandom_range(2101, 4095));
         end
         month = MonthWidth'($urandom_range(1, 12));
         len   = month_length(month, year);
         day   = DayWidth'($urandom_range(1, len));
         if ($urandom_range(99) < 25) begin
            kind = $urandom_range(3);
            case (kind)
               0: begin
                  day   = DayWidth'($urandom);
                  month = MonthWidth'($urandom);
                  year  = YearWidth'($urandom);
               end
               1: year = YearWidth'($urandom_range(0, 2000));
               2: begin
                  month = MonthWidth'($urandom_range(0, 3));
                  if (month != 0) begin
                     month = MonthWidth'(month + 4'd12);
                  end
               end
               default: begin
                  if ($urandom_range(1)) begin
                     day = DayWidth'($urandom_range(len + 1, 63));
                  end else begin
                     day = '0;
                  end
               end
            endcase
         end
      end
   endtask

   task automatic wait_for_results();
      begin
         while (pending_weekdays.size() != 0) begin
            @(negedge clock);
         end
      end
   endtask

   task automatic test_directed();
      begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
         send_date(6'd1, 4'd1, 12'd2001);
         send_date(6'd31, 4'd12, 12'd2000);
         send_date(6'd1, 4'd1, 12'd0);
         send_date(6'd31, 4'd12, 12'd4095);
         send_date(6'd31, 4'd12, 12'd4092);
         send_date(6'd10, 4'd0, 12'd2010);
         send_date(6'd10, 4'd13, 12'd2010);
         send_date(6'd10, 4'd15, 12'd2010);
         send_date(6'd0, 4'd5, 12'd2010);
         send_date(6'd63, 4'd5, 12'd2010);
         send_date(6'd63, 4'd15, 12'd4095);
         send_date(6'd29, 4'd2, 12'd2004);
         send_date(6'd29, 4'd2, 12'd2001);
         send_date(6'd29, 4'd2, 12'd2100);
         send_date(6'd28, 4'd2, 12'd2001);
         send_date(6'd30, 4'd2, 12'd2004);
         send_date(6'd31, 4'd4, 12'd2020);
         send_date(6'd30, 4'd4, 12'd2020);
         send_date(6'd1, 4'd3, 12'd2004);
         send_date(6'd1, 4'd3, 12'd2005);
         send_date(6'd31, 4'd12, 12'd2099);
         send_date(6'd1, 4'd1, 12'd2100);
         send_date(6'd32, 4'd1, 12'd2024);
         send_date(6'd31, 4'd7, 12'd2024);
      end
   endtask

   task automatic test_random_phase(input int unsigned count, input int unsigned idle_pct,
                                    input int unsigned stall_pct);
      logic [DayWidth-1:0]   day;
      logic [MonthWidth-1:0] month;
      logic [YearWidth-1:0]  year;
      begin
         send_idle_pct  = idle_pct;
         recv_stall_pct = stall_pct;
         repeat (count) begin
            pick_date(day, month, year);
            send_date(day, month, year);
         end
      end
   endtask

   task automatic test_backpressure();
      logic [DayWidth-1:0]   day;
      logic [MonthWidth-1:0] month;
      logic [YearWidth-1:0]  year;
      begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
         hold_request   = 300;
         repeat (40) begin
            pick_date(day, month, year);
            send_date(day, month, year);
         end
      end
   endtask

   task automatic test_drain_pause();
      logic [DayWidth-1:0]   day;
      logic [MonthWidth-1:0] month;
      logic [YearWidth-1:0]  year;
      begin
         send_idle_pct  = 0;
         recv_stall_pct = 47;
         repeat (4) begin
            repeat (5) begin
               pick_date(day, month, year);
               send_date(day, month, year);
            end
            req_tvalid <= 1'b0;
            @(negedge clock);
            wait_for_results();
         end
      end
   endtask

   // hold off the response side for a requested stretch, else stall at random
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      weekday_expect_type exp_item;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_weekdays.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transaction, expected none, actual tdata %0h tuser %0b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            exp_item = pending_weekdays.pop_front();
            if (rsp_tdata !== RspWidth'(exp_item.weekday)
                || rsp_tuser !== exp_item.date_ok) begin
               error_count++;
               $display("%0t: mismatch %0d-%0d-%0d, expected %0d valid %0b, actual %0h valid %0b",
                        $time, exp_item.year, exp_item.month, exp_item.day,
                        exp_item.weekday, exp_item.date_ok, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_phase(150, 0, 0);
      test_random_phase(150, 47, 0);
      test_random_phase(150, 0, 47);
      test_random_phase(150, 35, 35);
      test_backpressure();
      test_drain_pause();
      req_tvalid <= 1'b0;
      @(negedge clock);
      wait_for_results();
      repeat (10) @(posedge clock);
      if (pending_weekdays.size() != 0) begin
         error_count++;
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== date_to_weekday.f =====
rtl/dtw_pkg.sv
rtl/dtw_check.sv
rtl/dtw_weekday.sv
rtl/date_to_weekday.sv
tb/sv/date_to_weekday_tb.sv
